/* src/gsig_pkg.sv */
`default_nettype none

package gsig_pkg;

   localparam int INDEX_BITS     = 24;
   localparam int MAX_GRID_DIM   = 4096;
   localparam int DIM_BITS       = 13;
   localparam int STEP_BITS      = 5;
   localparam int STRIP_BITS     = 12;
   localparam int ENTRY_BITS     = 14;
   localparam int COL_BITS       = 13;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 13;
   localparam int SW_BITS        = DIM_BITS + STEP_BITS;
   localparam int PROD_BITS      = STRIP_BITS + SW_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP_SIZE   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_STRIP = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_END_STRIP   = 3'd4;

   localparam logic [DIM_BITS-1:0]   RST_GRID_WIDTH  = 13'd65;
   localparam logic [DIM_BITS-1:0]   RST_GRID_HEIGHT = 13'd65;
   localparam logic [STEP_BITS-1:0]  RST_STEP_SIZE   = 5'd1;
   localparam logic [STRIP_BITS-1:0] RST_FIRST_STRIP = 12'd0;
   localparam logic [STRIP_BITS-1:0] RST_END_STRIP   = 12'd64;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_START,
      SEQ_DIVIDE,
      SEQ_MULT,
      SEQ_SUM
   } seq_state_type;

   // Geometry derived from the configuration registers.
   typedef struct packed {
      logic [ENTRY_BITS-1:0] len_m1;
      logic [STRIP_BITS-1:0] endc;
      logic [STRIP_BITS-1:0] last_row;
      logic [COL_BITS-1:0]   wm1;
      logic [STEP_BITS-1:0]  step;
      logic [COL_BITS-1:0]   tail;
      logic [STRIP_BITS-1:0] first;
   } geom_type;

endpackage

`default_nettype wire

/* src/gsig_req_if.sv */
`default_nettype none

interface gsig_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

/* src/gsig_rsp_if.sv */
`default_nettype none

interface gsig_rsp_if #(
   parameter int INDEX_BITS = gsig_pkg::INDEX_BITS
);
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] vertex_index;
   logic                  last_index;

   modport source (output valid, output vertex_index, output last_index, input ready);
   modport sink (input valid, input vertex_index, input last_index, output ready);
endinterface

`default_nettype wire

/* src/gsig_div.sv */
`default_nettype none

module gsig_div #(
   parameter int DIVIDEND_BITS = gsig_pkg::DIM_BITS,
   parameter int DIVISOR_BITS  = gsig_pkg::STEP_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [DIVIDEND_BITS-1:0] dividend,
   input  wire logic [DIVISOR_BITS-1:0]  divisor,
   output logic                          busy,
   output logic [DIVIDEND_BITS-1:0]      quotient
);

   localparam int COUNT_BITS = $clog2(DIVIDEND_BITS + 1);

   logic [COUNT_BITS-1:0]    count_ff, count_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  div_ff, div_in;
   logic [DIVISOR_BITS:0]    trial;
   logic                     fits;

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      trial    = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
      fits     = trial >= {1'b0, div_ff};
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         count_in = COUNT_BITS'(DIVIDEND_BITS);
         quo_in   = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         quo_in   = {quo_ff[DIVIDEND_BITS-2:0], fits};
         rem_in   = fits ? DIVISOR_BITS'(trial - {1'b0, div_ff}) : trial[DIVISOR_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy     = count_ff != '0;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

/* src/gsig_cfg.sv */
`default_nettype none

module gsig_cfg #(
   parameter int INDEX_BITS   = gsig_pkg::INDEX_BITS,
   parameter int MAX_GRID_DIM = gsig_pkg::MAX_GRID_DIM
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_enable,
   input  wire logic [gsig_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [gsig_pkg::CSR_DATA_BITS-1:0]   csr_write_data,
   input  wire logic [gsig_pkg::STRIP_BITS-1:0]      row,
   input  wire logic [gsig_pkg::ENTRY_BITS-1:0]      entry,
   output logic                                      busy,
   output gsig_pkg::geom_type                        geom,
   output logic [INDEX_BITS-1:0]                     sw,
   output logic [INDEX_BITS-1:0]                     fbase,
   output logic [INDEX_BITS-1:0]                     fbase_y,
   output logic [INDEX_BITS-1:0]                     fbase_pv,
   output logic                                      load_en,
   output logic [INDEX_BITS-1:0]                     load_x,
   output logic [INDEX_BITS-1:0]                     load_y,
   output logic [INDEX_BITS-1:0]                     load_pv,
   output logic [gsig_pkg::COL_BITS-1:0]             load_col
);

   localparam int DW = gsig_pkg::DIM_BITS;
   localparam int SB = gsig_pkg::STEP_BITS;
   localparam int RB = gsig_pkg::STRIP_BITS;
   localparam int EB = gsig_pkg::ENTRY_BITS;
   localparam int CB = gsig_pkg::COL_BITS;
   localparam int WB = gsig_pkg::SW_BITS;
   localparam int PB = gsig_pkg::PROD_BITS;

   logic [DW-1:0] width_ff, height_ff;
   logic [SB-1:0] step_ff;
   logic [RB-1:0] first_ff, end_ff;

   logic [DW-1:0] w_eff, h_eff, wm1;
   logic [SB-1:0] s_eff;

   gsig_pkg::seq_state_type seq_ff, seq_in;
   logic div_start, mult_en, sum_en;
   logic w_busy, h_busy;
   logic [DW-1:0] w_quo, h_quo;

   logic [WB-1:0] sw_ff;
   logic [PB-1:0] fbase_ff, xcur_ff;
   logic [WB-1:0] tail_ff, ks_ff;
   logic [EB-1:0] len_m1_ff;
   logic [RB-1:0] endc_ff, last_row_ff;
   logic [INDEX_BITS-1:0] fbase_y_ff, fbase_pv_ff;
   logic [DW-1:0] pair_k;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= gsig_pkg::RST_GRID_WIDTH;
         height_ff <= gsig_pkg::RST_GRID_HEIGHT;
         step_ff   <= gsig_pkg::RST_STEP_SIZE;
         first_ff  <= gsig_pkg::RST_FIRST_STRIP;
         end_ff    <= gsig_pkg::RST_END_STRIP;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            gsig_pkg::CSR_GRID_WIDTH:  width_ff  <= csr_write_data[DW-1:0];
            gsig_pkg::CSR_GRID_HEIGHT: height_ff <= csr_write_data[DW-1:0];
            gsig_pkg::CSR_STEP_SIZE:   step_ff   <= csr_write_data[SB-1:0];
            gsig_pkg::CSR_FIRST_STRIP: first_ff  <= csr_write_data[RB-1:0];
            gsig_pkg::CSR_END_STRIP:   end_ff    <= csr_write_data[RB-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      w_eff = (32'(width_ff) > MAX_GRID_DIM) ? DW'(MAX_GRID_DIM) : width_ff;
      h_eff = (32'(height_ff) > MAX_GRID_DIM) ? DW'(MAX_GRID_DIM) : height_ff;
      s_eff = (step_ff == '0) ? SB'(1) : step_ff;
      wm1   = w_eff - 1'b1;
   end

   gsig_div #(.DIVIDEND_BITS(DW), .DIVISOR_BITS(SB)) u_div_w (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (wm1),
      .divisor  (s_eff),
      .busy     (w_busy),
      .quotient (w_quo)
   );

   gsig_div #(.DIVIDEND_BITS(DW), .DIVISOR_BITS(SB)) u_div_h (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (h_eff - 1'b1),
      .divisor  (s_eff),
      .busy     (h_busy),
      .quotient (h_quo)
   );

   // Sequencer that rebuilds the derived geometry after reset or a write.
   always_comb begin
      seq_in = seq_ff;
      if (csr_write_enable) begin
         seq_in = gsig_pkg::SEQ_START;
      end else begin
         unique case (seq_ff)
            gsig_pkg::SEQ_START:  seq_in = gsig_pkg::SEQ_DIVIDE;
            gsig_pkg::SEQ_DIVIDE: begin
               if (!w_busy && !h_busy) seq_in = gsig_pkg::SEQ_MULT;
            end
            gsig_pkg::SEQ_MULT:   seq_in = gsig_pkg::SEQ_SUM;
            gsig_pkg::SEQ_SUM:    seq_in = gsig_pkg::SEQ_IDLE;
            gsig_pkg::SEQ_IDLE:   seq_in = gsig_pkg::SEQ_IDLE;
            default:              seq_in = gsig_pkg::SEQ_START;
         endcase
      end
   end

   always_comb begin
      busy      = seq_ff != gsig_pkg::SEQ_IDLE;
      div_start = seq_ff == gsig_pkg::SEQ_START;
      mult_en   = seq_ff == gsig_pkg::SEQ_MULT;
      sum_en    = seq_ff == gsig_pkg::SEQ_SUM;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= gsig_pkg::SEQ_START;
      end else begin
         seq_ff <= seq_in;
      end
   end

   // Pair index of the current entry; the leading entries share pair zero.
   assign pair_k = (entry < EB'(2)) ? '0 : DW'((entry - EB'(2)) >> 1);

   always_ff @(posedge clock) begin
      if (div_start) begin
         sw_ff <= WB'(s_eff) * WB'(w_eff);
      end
      if (mult_en) begin
         fbase_ff  <= PB'(first_ff) * PB'(sw_ff);
         xcur_ff   <= PB'(row) * PB'(sw_ff);
         tail_ff   <= WB'(w_quo) * WB'(s_eff);
         ks_ff     <= WB'(pair_k) * WB'(s_eff);
         len_m1_ff <= EB'({w_quo, 1'b0} + (DW + 1)'(3));
         if (w_eff == '0 || h_eff == '0) begin
            endc_ff <= '0;
         end else if (DW'(end_ff) < h_quo) begin
            endc_ff <= end_ff;
         end else begin
            endc_ff <= h_quo[RB-1:0];
         end
      end
      if (sum_en) begin
         fbase_y_ff  <= INDEX_BITS'(fbase_ff) + INDEX_BITS'(sw_ff);
         fbase_pv_ff <= INDEX_BITS'(fbase_ff) - INDEX_BITS'(sw_ff);
         last_row_ff <= endc_ff - 1'b1;
      end
   end

   always_comb begin
      load_en  = sum_en;
      load_x   = INDEX_BITS'(xcur_ff);
      load_y   = INDEX_BITS'(xcur_ff) + INDEX_BITS'(sw_ff);
      load_pv  = INDEX_BITS'(xcur_ff) - INDEX_BITS'(sw_ff);
      load_col = row[0] ? (CB'(wm1) - CB'(ks_ff)) : CB'(ks_ff);
   end

   always_comb begin
      geom.len_m1   = len_m1_ff;
      geom.endc     = endc_ff;
      geom.last_row = last_row_ff;
      geom.wm1      = CB'(wm1);
      geom.step     = s_eff;
      geom.tail     = CB'(tail_ff);
      geom.first    = first_ff;
      sw            = INDEX_BITS'(sw_ff);
      fbase         = INDEX_BITS'(fbase_ff);
      fbase_y       = fbase_y_ff;
      fbase_pv      = fbase_pv_ff;
   end

endmodule

`default_nettype wire

/* src/gsig_walk.sv */
`default_nettype none

module gsig_walk #(
   parameter int INDEX_BITS = gsig_pkg::INDEX_BITS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             fire,
   input  wire logic                             restart,
   input  wire gsig_pkg::geom_type               geom,
   input  wire logic [INDEX_BITS-1:0]            sw,
   input  wire logic [INDEX_BITS-1:0]            fbase,
   input  wire logic [INDEX_BITS-1:0]            fbase_y,
   input  wire logic [INDEX_BITS-1:0]            fbase_pv,
   input  wire logic                             load_en,
   input  wire logic [INDEX_BITS-1:0]            load_x,
   input  wire logic [INDEX_BITS-1:0]            load_y,
   input  wire logic [INDEX_BITS-1:0]            load_pv,
   input  wire logic [gsig_pkg::COL_BITS-1:0]    load_col,
   output logic [gsig_pkg::STRIP_BITS-1:0]       row,
   output logic [gsig_pkg::ENTRY_BITS-1:0]       entry,
   output logic                                  push,
   output logic [INDEX_BITS-1:0]                 index,
   output logic                                  last
);

   localparam int RB = gsig_pkg::STRIP_BITS;
   localparam int EB = gsig_pkg::ENTRY_BITS;
   localparam int CB = gsig_pkg::COL_BITS;

   logic          active_ff;
   logic [RB-1:0] row_ff;
   logic [EB-1:0] entry_ff;
   logic [INDEX_BITS-1:0] x_ff, y_ff, pv_ff;
   logic [CB-1:0] col_ff;

   logic [RB:0]   row_n;
   logic [EB-1:0] entry_n, entry_inc;
   logic          new_row, step_col, go, odd_n;
   logic [INDEX_BITS-1:0] x_n, y_n, pv_n, base, offset;
   logic [CB-1:0] col_n, col_start;

   always_comb begin
      entry_inc = entry_ff + 1'b1;
      row_n     = {1'b0, row_ff};
      entry_n   = entry_ff;
      new_row   = 1'b0;
      step_col  = 1'b0;
      if (restart) begin
         row_n   = {1'b0, geom.first};
         entry_n = '0;
      end else if (entry_inc > geom.len_m1) begin
         row_n   = {1'b0, row_ff} + 1'b1;
         entry_n = '0;
         new_row = 1'b1;
      end else begin
         entry_n = entry_inc;
         // The column moves on when leaving the odd entry of a pair.
         step_col = entry_ff[0] && (entry_ff >= EB'(3));
      end

      go        = fire && (restart || active_ff) && (row_n < {1'b0, geom.endc});
      odd_n     = row_n[0];
      col_start = odd_n ? geom.wm1 : '0;

      if (restart) begin
         x_n   = fbase;
         y_n   = fbase_y;
         pv_n  = fbase_pv;
         col_n = col_start;
      end else if (new_row) begin
         x_n   = y_ff;
         y_n   = y_ff + sw;
         pv_n  = x_ff;
         col_n = col_start;
      end else begin
         x_n   = x_ff;
         y_n   = y_ff;
         pv_n  = pv_ff;
         if (step_col) begin
            col_n = odd_n ? (col_ff - CB'(geom.step)) : (col_ff + CB'(geom.step));
         end else begin
            col_n = col_ff;
         end
      end

      // Odd rows open with copies of the previous row's tail.
      if (entry_n == '0) begin
         base   = odd_n ? pv_n : x_n;
         offset = odd_n ? INDEX_BITS'(geom.tail) : '0;
      end else if (entry_n == EB'(1)) begin
         base   = odd_n ? x_n : y_n;
         offset = odd_n ? INDEX_BITS'(geom.tail) : '0;
      end else begin
         base   = (entry_n[0] ^ odd_n) ? x_n : y_n;
         offset = INDEX_BITS'(col_n);
      end

      push  = go;
      index = base + offset;
      last  = (row_n == {1'b0, geom.last_row}) && (entry_n == geom.len_m1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         row_ff    <= '0;
         entry_ff  <= '0;
      end else begin
         if (fire && (restart || active_ff)) begin
            active_ff <= go;
         end
         if (go) begin
            row_ff   <= row_n[RB-1:0];
            entry_ff <= entry_n;
         end
      end
      if (load_en) begin
         x_ff   <= load_x;
         y_ff   <= load_y;
         pv_ff  <= load_pv;
         col_ff <= load_col;
      end else if (go) begin
         x_ff   <= x_n;
         y_ff   <= y_n;
         pv_ff  <= pv_n;
         col_ff <= col_n;
      end
   end

   assign row   = row_ff;
   assign entry = entry_ff;

endmodule

`default_nettype wire

/* src/gsig_skid.sv */
`default_nettype none

module gsig_skid #(
   parameter int WIDTH = gsig_pkg::INDEX_BITS + 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [WIDTH-1:0] in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [WIDTH-1:0]      out_data
);

   logic             main_valid_ff, skid_valid_ff;
   logic [WIDTH-1:0] main_data_ff, skid_data_ff;
   logic             pop;

   assign pop = main_valid_ff && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!main_valid_ff || pop) begin
         main_valid_ff <= in_valid;
      end else if (in_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) main_data_ff <= skid_data_ff;
      end else if (!main_valid_ff || pop) begin
         if (in_valid) main_data_ff <= in_data;
      end else if (in_valid) begin
         skid_data_ff <= in_data;
      end
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

endmodule

`default_nettype wire

/* src/grid_strip_index_generator.sv */
// Serpentine triangle-strip index generator over a vertex grid.
//
// The req channel carries one restart bit per word. A word with restart set
// starts the list at the first strip row; a word with it clear advances one
// index. Each accepted word gives at most one rsp word: the vertex index and
// a flag on the final index of the window. Advances while idle, past the end
// of the list, or a restart on an empty window give no rsp word.
// Configuration registers are written through the csr port at any time the
// block has no work in flight; each write, and reset, starts a rebuild of
// the derived geometry that keeps req ready low (a setup state, a 13-step
// shift-subtract division, a product stage and a sum stage). After that, one
// word is accepted every cycle while the skid register is empty. The rsp word
// is registered and, with no stall, shows on rsp the cycle after its req word
// is accepted. When the receiver stalls, one more word is held in a skid
// register, and req ready drops only once both output registers are full.
// Reset is synchronous and active high; it loads the register defaults and
// leaves the generator idle until a restart.
`default_nettype none

module grid_strip_index_generator #(
   parameter int INDEX_BITS   = gsig_pkg::INDEX_BITS,
   parameter int MAX_GRID_DIM = gsig_pkg::MAX_GRID_DIM
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   gsig_req_if.sink                                  req_if,
   gsig_rsp_if.source                                rsp_if,
   input  wire logic                                 csr_write_enable,
   input  wire logic [gsig_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [gsig_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);

   gsig_pkg::geom_type                   geom;
   logic                                 cfg_busy;
   logic [INDEX_BITS-1:0]                sw, fbase, fbase_y, fbase_pv;
   logic                                 load_en;
   logic [INDEX_BITS-1:0]                load_x, load_y, load_pv;
   logic [gsig_pkg::COL_BITS-1:0]        load_col;
   logic [gsig_pkg::STRIP_BITS-1:0]      row;
   logic [gsig_pkg::ENTRY_BITS-1:0]      entry;
   logic                                 walk_push, walk_last;
   logic [INDEX_BITS-1:0]                walk_index;
   logic                                 skid_ready, req_fire;
   logic [INDEX_BITS:0]                  rsp_data;

   assign req_if.ready = !cfg_busy && skid_ready;
   assign req_fire     = req_if.valid && req_if.ready;

   gsig_cfg #(.INDEX_BITS(INDEX_BITS), .MAX_GRID_DIM(MAX_GRID_DIM)) u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .row              (row),
      .entry            (entry),
      .busy             (cfg_busy),
      .geom             (geom),
      .sw               (sw),
      .fbase            (fbase),
      .fbase_y          (fbase_y),
      .fbase_pv         (fbase_pv),
      .load_en          (load_en),
      .load_x           (load_x),
      .load_y           (load_y),
      .load_pv          (load_pv),
      .load_col         (load_col)
   );

   gsig_walk #(.INDEX_BITS(INDEX_BITS)) u_walk (
      .clock    (clock),
      .reset    (reset),
      .fire     (req_fire),
      .restart  (req_if.restart),
      .geom     (geom),
      .sw       (sw),
      .fbase    (fbase),
      .fbase_y  (fbase_y),
      .fbase_pv (fbase_pv),
      .load_en  (load_en),
      .load_x   (load_x),
      .load_y   (load_y),
      .load_pv  (load_pv),
      .load_col (load_col),
      .row      (row),
      .entry    (entry),
      .push     (walk_push),
      .index    (walk_index),
      .last     (walk_last)
   );

   gsig_skid #(.WIDTH(INDEX_BITS + 1)) u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (walk_push),
      .in_ready  (skid_ready),
      .in_data   ({walk_last, walk_index}),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (rsp_data)
   );

   assign rsp_if.vertex_index = rsp_data[INDEX_BITS-1:0];
   assign rsp_if.last_index   = rsp_data[INDEX_BITS];

   // A register write must hold off new words while the geometry is rebuilt.
   a_csr_blocks_req: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> !req_if.ready)
      else $error("req ready high right after a register write");

   // Results come only from accepted words.
   a_push_from_req: assert property (@(posedge clock) disable iff (reset)
      walk_push |-> req_fire)
      else $error("result produced without an accepted req word");

   // The output registers always have room for a new result.
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      walk_push |-> skid_ready)
      else $error("result pushed into full output registers");

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;

   localparam int CSR_BITS = gsig_pkg::CSR_DATA_BITS;

   typedef struct packed {
      logic [gsig_pkg::INDEX_BITS-1:0] vertex;
      logic                            last;
   } strip_word_type;

   logic                                clock;
   logic                                reset;
   logic                                csr_write_enable;
   logic [gsig_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_BITS-1:0]                 csr_write_data;

   gsig_req_if req_if ();
   gsig_rsp_if rsp_if ();

   grid_strip_index_generator i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .rsp_if           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the registers and of the walk position.
   logic [gsig_pkg::DIM_BITS-1:0]   cfg_width;
   logic [gsig_pkg::DIM_BITS-1:0]   cfg_height;
   logic [gsig_pkg::STEP_BITS-1:0]  cfg_step;
   logic [gsig_pkg::STRIP_BITS-1:0] cfg_first;
   logic [gsig_pkg::STRIP_BITS-1:0] cfg_end;
   logic [gsig_pkg::STRIP_BITS-1:0] gen_row;
   logic [gsig_pkg::ENTRY_BITS-1:0] gen_entry;
   bit                              gen_active;

   strip_word_type expected_q[$];
   strip_word_type rsp_head;

   int errors = 0;
   int words_sent = 0;
   int indices_expected = 0;
   int indices_checked = 0;
   int last_seen = 0;
   int settings_count = 0;
   int hold_request = 0;
   int hold_left = 0;
   int stall_left = 0;
   bit rsp_stalls_on = 1'b1;
   bit req_gaps_on = 1'b1;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #5_000_000;
      $display("%0t: run did not finish in time", $time);
      $display("Simulation FAILED");
      $finish;
   end

   function automatic longint unsigned width_eff();
      return (cfg_width > gsig_pkg::MAX_GRID_DIM) ? 64'(gsig_pkg::MAX_GRID_DIM)
                                                 : 64'(cfg_width);
   endfunction

   function automatic longint unsigned step_eff();
      return (cfg_step == '0) ? 64'd1 : 64'(cfg_step);
   endfunction

   function automatic longint unsigned pairs_per_row();
      return (width_eff() == 0) ? 64'd0 : (width_eff() - 1) / step_eff() + 1;
   endfunction

   function automatic longint unsigned row_entries();
      return 2 * pairs_per_row() + 2;
   endfunction

   // One past the last strip row that is emitted.
   function automatic longint unsigned window_stop();
      longint unsigned h, rows;
      h = (cfg_height > gsig_pkg::MAX_GRID_DIM) ? 64'(gsig_pkg::MAX_GRID_DIM)
                                               : 64'(cfg_height);
      if (width_eff() == 0 || h == 0)
         return 64'd0;
      rows = (h - 1) / step_eff();
      return (64'(cfg_end) < rows) ? 64'(cfg_end) : rows;
   endfunction

   // Moves the shadow walk by one request word; returns 1 when an index comes out.
   function automatic bit next_vertex(input bit restart_bit, output strip_word_type word);
      longint unsigned row_stop, len, r, e, w, s, lo, hi, col, v;
      row_stop = window_stop();
      len = row_entries();
      w = width_eff();
      s = step_eff();
      word = '0;
      if (restart_bit) begin
         r = 64'(cfg_first);
         e = 0;
      end else begin
         if (!gen_active)
            return 0;
         r = 64'(gen_row);
         e = 64'(gen_entry) + 1;
         if (e >= len) begin
            e = 0;
            r++;
         end
      end
      if (r >= row_stop) begin
         gen_active = 1'b0;
         return 0;
      end
      gen_active = 1'b1;
      gen_row = r[gsig_pkg::STRIP_BITS-1:0];
      gen_entry = e[gsig_pkg::ENTRY_BITS-1:0];
      lo = r * s * w;
      hi = (r + 1) * s * w;
      if (r[0] == 1'b0) begin
         if (e == 0)
            v = lo;
         else if (e == 1)
            v = hi;
         else begin
            col = ((e - 2) / 2) * s;
            v = e[0] ? lo + col : hi + col;
         end
      end else begin
         // Odd rows open with two copies of the previous row's tail.
         if (e == 0)
            v = (r - 1) * s * w + (pairs_per_row() - 1) * s;
         else if (e == 1)
            v = lo + (pairs_per_row() - 1) * s;
         else begin
            col = (w - 1) - ((e - 2) / 2) * s;
            v = e[0] ? hi + col : lo + col;
         end
      end
      word.vertex = v[gsig_pkg::INDEX_BITS-1:0];
      word.last = (r + 1 == row_stop) && (e + 1 == len);
      return 1;
   endfunction

   task automatic send_word(input bit restart_bit);
      strip_word_type word;
      int gap;
      req_if.valid <= 1'b1;
      req_if.restart <= restart_bit;
      @(posedge clock);
      while (req_if.ready !== 1'b1)
         @(posedge clock);
      words_sent++;
      if (next_vertex(restart_bit, word)) begin
         expected_q.push_back(word);
         indices_expected++;
      end
      gap = 0;
      if (req_gaps_on) begin
         if ($urandom_range(0, 29) == 0)
            gap = $urandom_range(8, 30);
         else if ($urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Registers are only written once nothing is in flight.
   task automatic settle();
      req_if.valid <= 1'b0;
      while (expected_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_regs(input bit [4:0] sel, input logic [CSR_BITS-1:0] w_val,
                             input logic [CSR_BITS-1:0] h_val,
                             input logic [CSR_BITS-1:0] s_val,
                             input logic [CSR_BITS-1:0] f_val,
                             input logic [CSR_BITS-1:0] e_val);
      logic [CSR_BITS-1:0]                 vals [5];
      logic [gsig_pkg::CSR_INDEX_BITS-1:0] ids [5];
      vals = '{w_val, h_val, s_val, f_val, e_val};
      ids = '{gsig_pkg::CSR_GRID_WIDTH, gsig_pkg::CSR_GRID_HEIGHT,
              gsig_pkg::CSR_STEP_SIZE, gsig_pkg::CSR_FIRST_STRIP,
              gsig_pkg::CSR_END_STRIP};
      for (int i = 0; i < 5; i++) begin
         if (sel[i]) begin
            csr_write_enable <= 1'b1;
            csr_index <= ids[i];
            csr_write_data <= vals[i];
            @(posedge clock);
            unique case (ids[i])
               gsig_pkg::CSR_GRID_WIDTH:  cfg_width = vals[i];
               gsig_pkg::CSR_GRID_HEIGHT: cfg_height = vals[i];
               gsig_pkg::CSR_STEP_SIZE:   cfg_step = vals[i][gsig_pkg::STEP_BITS-1:0];
               gsig_pkg::CSR_FIRST_STRIP: cfg_first = vals[i][gsig_pkg::STRIP_BITS-1:0];
               gsig_pkg::CSR_END_STRIP:   cfg_end = vals[i][gsig_pkg::STRIP_BITS-1:0];
               default: ;
            endcase
         end
      end
      csr_write_enable <= 1'b0;
      settings_count++;
   endtask

   task automatic test_idle_after_reset();
      send_word(1'b0);
      settle();
   endtask

   task automatic test_default_grid();
      send_word(1'b1);
      repeat (2) send_word(1'b0);
      settle();
   endtask

   // A single strip row, walked to its flagged end and beyond.
   task automatic test_full_list();
      write_regs(5'b11111, 13'd2, 13'd2, 13'd1, 13'd0, 13'h1FFF);
      send_word(1'b1);
      repeat (7) send_word(1'b0);
      settle();
   endtask

   task automatic test_empty_window();
      write_regs(5'b11111, 13'd20, 13'd20, 13'd1, 13'd5, 13'd3);
      send_word(1'b1);
      settle();
      write_regs(5'b00001, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0);
      send_word(1'b1);
      settle();
   endtask

   // Oversized dimensions saturate and a zero step counts as one.
   task automatic test_large_grid();
      write_regs(5'b11111, 13'h1FFF, 13'h1FFF, 13'd0, 13'd4094, 13'h1FFF);
      send_word(1'b1);
      repeat (2) send_word(1'b0);
      settle();
   endtask

   task automatic test_coarse_step();
      write_regs(5'b11111, 13'd4096, 13'd4096, 13'd31, 13'd131, 13'd4095);
      send_word(1'b1);
      repeat (2) send_word(1'b0);
      settle();
      // Pulling the window end below the current row sends the walk idle.
      write_regs(5'b10000, 13'd0, 13'd0, 13'd0, 13'd0, 13'd131);
      repeat (2) send_word(1'b0);
      settle();
   endtask

   task automatic test_backpressure();
      rsp_stalls_on = 1'b0;
      req_gaps_on = 1'b0;
      write_regs(5'b11111, CSR_BITS'(gsig_pkg::RST_GRID_WIDTH),
                 CSR_BITS'(gsig_pkg::RST_GRID_HEIGHT),
                 CSR_BITS'(gsig_pkg::RST_STEP_SIZE),
                 CSR_BITS'(gsig_pkg::RST_FIRST_STRIP),
                 CSR_BITS'(gsig_pkg::RST_END_STRIP));
      hold_request = 60;
      send_word(1'b1);
      repeat (24) send_word(1'b0);
      settle();
      rsp_stalls_on = 1'b1;
      req_gaps_on = 1'b1;
   endtask

   task automatic test_random_lists();
      int base, kind, n_adv, reg_pick;
      longint unsigned total, rows, hh, ss;
      logic [CSR_BITS-1:0] w, h, st, fs, es;
      base = words_sent;
      while (words_sent - base < 550) begin
         kind = $urandom_range(0, 9);
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_stalls_on = ($urandom_range(0, 3) != 0);
         w = CSR_BITS'($urandom_range(2, 12));
         h = CSR_BITS'($urandom_range(2, 12));
         st = ($urandom_range(0, 7) == 0) ? '0 : CSR_BITS'($urandom_range(1, 4));
         fs = CSR_BITS'($urandom_range(0, 3));
         es = $urandom_range(0, 1) ? 13'h0FFF : CSR_BITS'($urandom_range(0, 10));
         if (kind == 9) begin
            // Change one register and carry on from the current position.
            reg_pick = $urandom_range(0, 4);
            write_regs(5'b00001 << reg_pick, w, h, st, fs, es);
            n_adv = $urandom_range(2, 15);
         end else begin
            if (kind == 7) begin
               w = CSR_BITS'($urandom_range(2, 8191));
               h = CSR_BITS'($urandom_range(2, 8191));
               st = CSR_BITS'($urandom_range(0, 31));
               hh = (h > gsig_pkg::MAX_GRID_DIM) ? 64'(gsig_pkg::MAX_GRID_DIM) : 64'(h);
               ss = (st == '0) ? 64'd1 : 64'(st);
               rows = (hh - 1) / ss;
               if (rows >= 2)
                  fs = CSR_BITS'($urandom_range(32'(rows - 2), 32'(rows)));
               else
                  fs = '0;
               es = $urandom_range(0, 1) ? 13'h0FFF : CSR_BITS'(rows);
            end else if (kind == 8) begin
               w = CSR_BITS'($urandom_range(0, 8191));
               h = CSR_BITS'($urandom_range(0, 8191));
               st = CSR_BITS'($urandom_range(0, 8191));
               fs = CSR_BITS'($urandom_range(0, 8191));
               es = CSR_BITS'($urandom_range(0, 8191));
            end
            write_regs(5'b11111, w, h, st, fs, es);
            total = (window_stop() > 64'(cfg_first)) ?
                    (window_stop() - 64'(cfg_first)) * row_entries() : 64'd0;
            n_adv = (total > 40) ? int'($urandom_range(10, 40))
                                 : int'(total) + int'($urandom_range(0, 2));
            send_word(1'b1);
         end
         repeat (n_adv) send_word($urandom_range(0, 24) == 0);
         settle();
      end
   endtask

   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            if (rsp_stalls_on && $urandom_range(0, 5) == 0)
               stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected word, vertex_index %0d last_index %0b",
                     $time, rsp_if.vertex_index, rsp_if.last_index);
            errors++;
         end else begin
            rsp_head = expected_q.pop_front();
            indices_checked++;
            if (rsp_head.last)
               last_seen++;
            if (rsp_if.vertex_index !== rsp_head.vertex) begin
               $display("%0t: vertex_index expected %0d, actual %0d",
                        $time, rsp_head.vertex, rsp_if.vertex_index);
               errors++;
            end
            if (rsp_if.last_index !== rsp_head.last) begin
               $display("%0t: last_index expected %0b, actual %0b",
                        $time, rsp_head.last, rsp_if.last_index);
               errors++;
            end
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.restart <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index <= gsig_pkg::CSR_GRID_WIDTH;
      csr_write_data <= '0;
      cfg_width = gsig_pkg::RST_GRID_WIDTH;
      cfg_height = gsig_pkg::RST_GRID_HEIGHT;
      cfg_step = gsig_pkg::RST_STEP_SIZE;
      cfg_first = gsig_pkg::RST_FIRST_STRIP;
      cfg_end = gsig_pkg::RST_END_STRIP;
      gen_row = '0;
      gen_entry = '0;
      gen_active = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_idle_after_reset();
      test_default_grid();
      test_full_list();
      test_empty_window();
      test_large_grid();
      test_coarse_step();
      test_backpressure();
      test_random_lists();

      $display("Sent %0d request words over %0d register settings.",
               words_sent, settings_count);
      $display("Checked %0d vertex indices, %0d of them flagged as list end.",
               indices_checked, last_seen);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
